// ===== rtl/pkl_pkg.sv =====
// shared constants and types for the running k-th largest selector
package pkl_pkg;

    // number of cells in the chain, the largest rank that can be reported
    localparam int K_MAX  = 64;
    localparam int DATA_W = 32;
    localparam int RANK_W = 7;
    localparam int IDX_W  = (K_MAX > 1) ? $clog2(K_MAX) : 1;

    // what one cell hands to the next one down the chain
    typedef struct packed {
        logic                     held;   // cell holds a value of this sequence
        logic                     keep;   // held value is no smaller than the new sample
        logic signed [DATA_W-1:0] value;  // held value
    } t_link;

endpackage

// ===== rtl/prefix_kth_largest_top.sv =====
// top level of the running k-th largest selector: cell chain, rank register, output stage
//
// Input channel: i_valid / o_stall carry i_sample (signed) and i_first. A beat is taken
// at a rising edge with i_valid high and o_stall low. i_first starts a new sequence and
// empties the chain before the sample is inserted.
// Output channel: o_valid / i_stall carry o_kth_value, the rank-th largest value of the
// current sequence. A beat gives a result only once the sequence holds at least rank
// values; earlier beats give none.
// Rank register: written by i_cfg_wr_en / i_cfg_wr_data, 0 reads as 1, values above the
// chain length read as the chain length. Write it only while the block is idle.
// Timing: every cell compares the sample with its value and shifts in the same cycle,
// so one beat is taken per cycle while o_stall is low; a result appears in the output
// register in the cycle after its input beat.
// Stall: while a result waits under i_stall, o_stall is raised and no input is taken;
// once the waiting result is taken the next beat is accepted in the same cycle.
// Reset (synchronous, active low): the chain is empty, the rank is 1 and the output
// register holds nothing. No clearing pass is needed.
module prefix_kth_largest_top
    import pkl_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [DATA_W-1:0] i_sample,
    input  logic                     i_first,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_kth_value,
    input  logic                     i_cfg_wr_en,
    input  logic [RANK_W-1:0]        i_cfg_wr_data
);

    logic [RANK_W-1:0]        r_rank;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_kth_value;
    logic                     in_accept;
    logic [IDX_W-1:0]         rank_idx;
    logic                     hit;

    t_link                    link     [0:K_MAX];
    logic                     nx_held  [0:K_MAX-1];
    logic signed [DATA_W-1:0] nx_value [0:K_MAX-1];
    logic [K_MAX-1:0]         held_q;

    // input taken while the output register is free or being emptied
    assign o_stall   = r_out_valid & i_stall;
    assign in_accept = i_valid & ~o_stall;

    // rank register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= RANK_W'(1);
        end else if (i_cfg_wr_en) begin
            r_rank <= i_cfg_wr_data;
        end
    end

    // clamp the rank into the chain and turn it into a cell index
    always_comb begin
        if (r_rank == '0) begin
            rank_idx = '0;
        end else if (int'(r_rank) > K_MAX) begin
            rank_idx = IDX_W'(K_MAX - 1);
        end else begin
            rank_idx = IDX_W'(r_rank - RANK_W'(1));
        end
    end

    // head of the chain: the sample always lands at or below the first cell
    assign link[0] = '{held: 1'b1, keep: 1'b1, value: '0};

    // compare-and-shift cells
    for (genvar g = 0; g < K_MAX; g++) begin : g_cell
        pkl_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_load       (in_accept),
            .i_flush      (i_first),
            .i_sample     (i_sample),
            .i_prev       (link[g]),
            .o_link       (link[g+1]),
            .o_next_held  (nx_held[g]),
            .o_next_value (nx_value[g]),
            .o_held_q     (held_q[g])
        );
    end

    // the sequence holds at least rank values when the rank cell fills
    assign hit = nx_held[rank_idx];

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && hit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && hit) begin
            r_kth_value <= nx_value[rank_idx];
        end
    end

    assign o_valid     = r_out_valid;
    assign o_kth_value = r_kth_value;

`ifndef SYNTHESIS
    // a new sequence leaves exactly the first cell filled
    a_first_one_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_first) |=> (held_q[0] && $countones(held_q) == 1))
        else $error("new sequence did not leave a single filled cell");

    // rank one always answers, so any accepted beat at rank one gives a result
    a_rank_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && rank_idx == '0) |=> o_valid)
        else $error("no result for a beat at rank one");

    // a waiting result is never dropped
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_kth_value)))
        else $error("stalled result lost or changed");

    // the head of the chain stays in descending order
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (K_MAX > 1 && held_q[K_MAX > 1 ? 1 : 0] && !$past(!i_rst_n))
        |-> (link[K_MAX > 1 ? 2 : 1].value <= link[1].value))
        else $error("chain head out of order");
`endif

endmodule

// ===== rtl/pkl_cell.sv =====
// one compare-and-shift cell of the descending sorted chain
module pkl_cell
    import pkl_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  logic                     i_flush,
    input  logic signed [DATA_W-1:0] i_sample,
    input  t_link                    i_prev,
    output t_link                    o_link,
    output logic                     o_next_held,
    output logic signed [DATA_W-1:0] o_next_value,
    output logic                     o_held_q
);

    logic                     r_held;
    logic signed [DATA_W-1:0] r_value;
    logic                     n_held;
    logic signed [DATA_W-1:0] n_value;
    logic                     eff_held;
    logic                     keep;

    // a new sequence empties the cell before the sample goes in
    assign eff_held = r_held & ~i_flush;
    // ties stay above the new sample
    assign keep     = eff_held & (r_value >= i_sample);

    // keep own value, take the sample, or take the neighbour's value
    always_comb begin
        n_held = eff_held | i_prev.held;
        if (keep) begin
            n_value = r_value;
        end else if (i_prev.keep) begin
            n_value = i_sample;
        end else begin
            n_value = i_prev.value;
        end
    end

    // cell state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
        end else if (i_load) begin
            r_held <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_value <= n_value;
        end
    end

    assign o_link       = '{held: eff_held, keep: keep, value: r_value};
    assign o_next_held  = n_held;
    assign o_next_value = n_value;
    assign o_held_q     = r_held;

endmodule
